// ----- rtl/dmpe_pkg.sv -----
// ----------------------------------------------------------------------------
// dmpe_pkg
// Shared types, codes, register reset values and helpers for the
// two-motor forward Euler step core.
// ----------------------------------------------------------------------------
package dmpe_pkg;

    localparam int unsigned COEF_W    = 31;
    localparam int unsigned DATA_W    = 32;
    localparam int unsigned REG_IDX_W = 3;
    localparam int unsigned FUNC_W    = 2;

    typedef logic [COEF_W-1:0]        t_coef;
    typedef logic signed [DATA_W-1:0] t_q;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_SET_LEFT  = 2'd0,
        FUNC_SET_RIGHT = 2'd1,
        FUNC_TICK      = 2'd2
    } t_func;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_SPEED_DECAY = 3'd0,
        REG_TORQUE      = 3'd1,
        REG_BACK_EMF    = 3'd2,
        REG_RESIST      = 3'd3,
        REG_DRIVE       = 3'd4,
        REG_V_MAX       = 3'd5,
        REG_FWD_SCALE   = 3'd6,
        REG_TURN_SCALE  = 3'd7
    } t_reg_idx;

    typedef struct packed {
        t_coef speed_decay;
        t_coef torque;
        t_coef back_emf;
        t_coef resist;
        t_coef drive;
        t_coef v_max;
        t_coef fwd_scale;
        t_coef turn_scale;
    } t_coef_regs;

    localparam t_coef RST_SPEED_DECAY = 31'd10923;
    localparam t_coef RST_TORQUE      = 31'd1092;
    localparam t_coef RST_BACK_EMF    = 31'd22;
    localparam t_coef RST_RESIST      = 31'd2185;
    localparam t_coef RST_DRIVE       = 31'd2185;
    localparam t_coef RST_V_MAX       = 31'd327680;
    localparam t_coef RST_FWD_SCALE   = 31'd131072;
    localparam t_coef RST_TURN_SCALE  = 31'd524288;

    // clamp to the signed 32-bit range
    function automatic t_q sat32(input logic signed [63:0] v);
        t_q res;
        if (v > 64'sh0000_0000_7fff_ffff) begin
            res = 32'sh7fff_ffff;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

// ----- rtl/dmpe_in_if.sv -----
// ----------------------------------------------------------------------------
// dmpe_in_if
// Input item channel: motor voltage set or tick request.
// ----------------------------------------------------------------------------
interface dmpe_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        func;
    logic signed [31:0] voltage;

    modport source (output valid, output func, output voltage, input ready);
    modport sink   (input valid, input func, input voltage, output ready);
endinterface

// ----- rtl/dmpe_out_if.sv -----
// ----------------------------------------------------------------------------
// dmpe_out_if
// Result item channel: wheel angles, forward velocity and turn rate.
// ----------------------------------------------------------------------------
interface dmpe_out_if;
    logic              valid;
    logic              ready;
    logic signed [31:0] pos_left;
    logic signed [31:0] pos_right;
    logic signed [31:0] forward_vel;
    logic signed [31:0] turn_rate;

    modport source (output valid, output pos_left, output pos_right,
                    output forward_vel, output turn_rate, input ready);
    modport sink   (input valid, input pos_left, input pos_right,
                    input forward_vel, input turn_rate, output ready);
endinterface

// ----- rtl/dmpe_cfg.sv -----
// ----------------------------------------------------------------------------
// dmpe_cfg
// Coefficient register file, written through a plain write port.
// ----------------------------------------------------------------------------
module dmpe_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [dmpe_pkg::REG_IDX_W-1:0]      i_cfg_idx,
    input  logic [dmpe_pkg::COEF_W-1:0]         i_cfg_data,
    output dmpe_pkg::t_coef_regs                o_coef
);

    dmpe_pkg::t_coef_regs r_coef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef.speed_decay <= dmpe_pkg::RST_SPEED_DECAY;
            r_coef.torque      <= dmpe_pkg::RST_TORQUE;
            r_coef.back_emf    <= dmpe_pkg::RST_BACK_EMF;
            r_coef.resist      <= dmpe_pkg::RST_RESIST;
            r_coef.drive       <= dmpe_pkg::RST_DRIVE;
            r_coef.v_max       <= dmpe_pkg::RST_V_MAX;
            r_coef.fwd_scale   <= dmpe_pkg::RST_FWD_SCALE;
            r_coef.turn_scale  <= dmpe_pkg::RST_TURN_SCALE;
        end else if (i_cfg_we) begin
            unique case (dmpe_pkg::t_reg_idx'(i_cfg_idx))
                dmpe_pkg::REG_SPEED_DECAY: r_coef.speed_decay <= i_cfg_data;
                dmpe_pkg::REG_TORQUE:      r_coef.torque      <= i_cfg_data;
                dmpe_pkg::REG_BACK_EMF:    r_coef.back_emf    <= i_cfg_data;
                dmpe_pkg::REG_RESIST:      r_coef.resist      <= i_cfg_data;
                dmpe_pkg::REG_DRIVE:       r_coef.drive       <= i_cfg_data;
                dmpe_pkg::REG_V_MAX:       r_coef.v_max       <= i_cfg_data;
                dmpe_pkg::REG_FWD_SCALE:   r_coef.fwd_scale   <= i_cfg_data;
                dmpe_pkg::REG_TURN_SCALE:  r_coef.turn_scale  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_coef = r_coef;

endmodule

// ----- rtl/dmpe_mul_round.sv -----
// ----------------------------------------------------------------------------
// dmpe_mul_round
// Unsigned coefficient times signed value, rounded to FRAC_BITS fraction
// bits to nearest with ties away from zero.
// ----------------------------------------------------------------------------
module dmpe_mul_round #(
    parameter int FRAC_BITS = 16
) (
    input  logic [dmpe_pkg::COEF_W-1:0]  i_coef,
    input  logic signed [32:0]           i_x,
    output logic signed [64-FRAC_BITS:0] o_prod
);

    logic [32:0]             mag;
    logic [63:0]             prod;
    logic [63:0]             rnd;
    logic [63-FRAC_BITS:0]   rmag;

    always_comb begin
        mag    = i_x[32] ? $unsigned(-i_x) : $unsigned(i_x);
        prod   = 64'(mag) * 64'(i_coef);
        rnd    = (prod + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        rmag   = rnd[63-FRAC_BITS:0];
        o_prod = i_x[32] ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
    end

endmodule

// ----- rtl/dmpe_motor.sv -----
// ----------------------------------------------------------------------------
// dmpe_motor
// State and forward Euler update of one armature motor: drive voltage,
// current, speed and wrapping angle.
// ----------------------------------------------------------------------------
module dmpe_motor #(
    parameter int TICK_RATE = 60,
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dmpe_pkg::t_coef_regs i_coef,
    input  logic                 i_set,
    input  dmpe_pkg::t_q         i_volts,
    input  logic                 i_tick,
    output dmpe_pkg::t_q         o_speed,
    output logic [31:0]          o_angle
);

    localparam int RW = 65 - FRAC_BITS;
    localparam int SW = RW + 3;

    // exact reciprocal multiply for the rounded division by the tick rate
    localparam int          DIV_SHIFT = 32 + $clog2(TICK_RATE);
    localparam int          PW        = DIV_SHIFT + 34;
    localparam logic [33:0] DIV_MUL   =
        34'(((64'd1 << DIV_SHIFT) + 64'(TICK_RATE) - 64'd1) / 64'(TICK_RATE));
    localparam logic [31:0] DIV_HALF  = 32'(TICK_RATE / 2);

    dmpe_pkg::t_q r_current;
    dmpe_pkg::t_q r_speed;
    logic [31:0]  r_angle;
    dmpe_pkg::t_q r_volts;

    logic signed [RW-1:0] p_decay;
    logic signed [RW-1:0] p_torque;
    logic signed [RW-1:0] p_emf;
    logic signed [RW-1:0] p_resist;
    logic signed [RW-1:0] p_drive;

    logic signed [SW-1:0] sum_speed;
    logic signed [SW-1:0] sum_current;
    dmpe_pkg::t_q         n_speed;
    dmpe_pkg::t_q         n_current;
    logic [31:0]          n_angle;

    logic                 spd_neg;
    logic [31:0]          spd_mag;
    logic [31:0]          div_num;
    logic [PW-1:0]        div_prod;
    logic [31:0]          div_q;

    dmpe_mul_round #(.FRAC_BITS(FRAC_BITS)) u_mul_decay (
        .i_coef (i_coef.speed_decay),
        .i_x    (33'(r_speed)),
        .o_prod (p_decay)
    );

    dmpe_mul_round #(.FRAC_BITS(FRAC_BITS)) u_mul_torque (
        .i_coef (i_coef.torque),
        .i_x    (33'(r_current)),
        .o_prod (p_torque)
    );

    dmpe_mul_round #(.FRAC_BITS(FRAC_BITS)) u_mul_emf (
        .i_coef (i_coef.back_emf),
        .i_x    (33'(r_speed)),
        .o_prod (p_emf)
    );

    dmpe_mul_round #(.FRAC_BITS(FRAC_BITS)) u_mul_resist (
        .i_coef (i_coef.resist),
        .i_x    (33'(r_current)),
        .o_prod (p_resist)
    );

    dmpe_mul_round #(.FRAC_BITS(FRAC_BITS)) u_mul_drive (
        .i_coef (i_coef.drive),
        .i_x    (33'(r_volts)),
        .o_prod (p_drive)
    );

    always_comb begin
        sum_speed   = SW'(r_speed) - SW'(p_decay) + SW'(p_torque);
        sum_current = SW'(r_current) - SW'(p_emf) - SW'(p_resist) + SW'(p_drive);
        n_speed     = dmpe_pkg::sat32(64'(sum_speed));
        n_current   = dmpe_pkg::sat32(64'(sum_current));

        spd_neg  = r_speed[31];
        spd_mag  = spd_neg ? $unsigned(-r_speed) : $unsigned(r_speed);
        div_num  = spd_mag + DIV_HALF;
        div_prod = PW'(div_num) * PW'(DIV_MUL);
        div_q    = div_prod[DIV_SHIFT +: 32];
        n_angle  = r_angle + (spd_neg ? (32'd0 - div_q) : div_q);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_current <= '0;
            r_speed   <= '0;
            r_angle   <= '0;
            r_volts   <= '0;
        end else begin
            if (i_set) begin
                r_volts <= i_volts;
            end
            if (i_tick) begin
                r_current <= n_current;
                r_speed   <= n_speed;
                r_angle   <= n_angle;
            end
        end
    end

    assign o_speed = r_speed;
    assign o_angle = r_angle;

endmodule

// ----- rtl/dc_motor_pair_euler_step_core.sv -----
// ----------------------------------------------------------------------------
// dc_motor_pair_euler_step_core
// Two armature DC motors stepped by forward Euler in signed fixed point.
// Set items load a clamped drive voltage; a tick reports both angles, the
// forward velocity and the turn rate, then advances both motors.
//
//   channel  dir  handshake      payload
//   i_in     in   valid/ready    func, voltage
//   o_out    out  valid/ready    pos_left, pos_right, forward_vel, turn_rate
//   i_cfg_*  in   write enable   i_cfg_idx, i_cfg_data
//
// One item per cycle while no tick stalls; a tick result follows the input
// register and the result register, and the whole update sits between them.
// A set item in the input register always moves on; a tick there waits only
// while the result register is full and not taken, and then input ready drops.
// Synchronous reset clears the motor state and loads the coefficient defaults.
// ----------------------------------------------------------------------------
module dc_motor_pair_euler_step_core #(
    parameter int TICK_RATE = 60,
    parameter int FRAC_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    dmpe_in_if.sink                        i_in,
    dmpe_out_if.source                     o_out,
    input  logic                           i_cfg_we,
    input  logic [dmpe_pkg::REG_IDX_W-1:0] i_cfg_idx,
    input  logic [dmpe_pkg::COEF_W-1:0]    i_cfg_data
);

    localparam int RW = 65 - FRAC_BITS;

    dmpe_pkg::t_coef_regs coef;

    logic                 r_in_valid;
    logic [1:0]           r_in_func;
    dmpe_pkg::t_q         r_in_voltage;

    logic                 r_out_valid;
    dmpe_pkg::t_q         r_pos_left;
    dmpe_pkg::t_q         r_pos_right;
    dmpe_pkg::t_q         r_forward_vel;
    dmpe_pkg::t_q         r_turn_rate;

    logic                 is_tick;
    logic                 is_set_left;
    logic                 is_set_right;
    logic                 adv;
    logic                 in_ready;

    logic signed [32:0]   volt_lim;
    logic signed [32:0]   volt_in;
    dmpe_pkg::t_q         volt_clamped;

    dmpe_pkg::t_q         speed_left;
    dmpe_pkg::t_q         speed_right;
    logic [31:0]          angle_left;
    logic [31:0]          angle_right;

    logic signed [32:0]   spd_sum;
    logic signed [32:0]   spd_diff;
    logic signed [RW-1:0] p_fwd;
    logic signed [RW-1:0] p_turn;

    dmpe_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_coef     (coef)
    );

    always_comb begin
        is_tick      = r_in_func == dmpe_pkg::FUNC_TICK;
        is_set_left  = r_in_func == dmpe_pkg::FUNC_SET_LEFT;
        is_set_right = r_in_func == dmpe_pkg::FUNC_SET_RIGHT;
        adv          = r_in_valid && (!is_tick || !r_out_valid || o_out.ready);
        in_ready     = !r_in_valid || adv;

        volt_lim = $signed({2'b00, coef.v_max});
        volt_in  = 33'(r_in_voltage);
        if (volt_in > volt_lim) begin
            volt_clamped = volt_lim[31:0];
        end else if (volt_in < -volt_lim) begin
            volt_clamped = 32'(-volt_lim);
        end else begin
            volt_clamped = r_in_voltage;
        end

        spd_sum  = 33'(speed_left) + 33'(speed_right);
        spd_diff = 33'(speed_right) - 33'(speed_left);
    end

    dmpe_motor #(.TICK_RATE(TICK_RATE), .FRAC_BITS(FRAC_BITS)) u_motor_left (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_coef  (coef),
        .i_set   (adv && is_set_left),
        .i_volts (volt_clamped),
        .i_tick  (adv && is_tick),
        .o_speed (speed_left),
        .o_angle (angle_left)
    );

    dmpe_motor #(.TICK_RATE(TICK_RATE), .FRAC_BITS(FRAC_BITS)) u_motor_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_coef  (coef),
        .i_set   (adv && is_set_right),
        .i_volts (volt_clamped),
        .i_tick  (adv && is_tick),
        .o_speed (speed_right),
        .o_angle (angle_right)
    );

    dmpe_mul_round #(.FRAC_BITS(FRAC_BITS)) u_mul_fwd (
        .i_coef (coef.fwd_scale),
        .i_x    (spd_sum),
        .o_prod (p_fwd)
    );

    dmpe_mul_round #(.FRAC_BITS(FRAC_BITS)) u_mul_turn (
        .i_coef (coef.turn_scale),
        .i_x    (spd_diff),
        .o_prod (p_turn)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_in.valid;
        end
        if (in_ready && i_in.valid) begin
            r_in_func    <= i_in.func;
            r_in_voltage <= i_in.voltage;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && is_tick) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (adv && is_tick) begin
            r_pos_left    <= $signed(angle_left);
            r_pos_right   <= $signed(angle_right);
            r_forward_vel <= dmpe_pkg::sat32(64'(p_fwd));
            r_turn_rate   <= dmpe_pkg::sat32(64'(p_turn));
        end
    end

    assign i_in.ready        = in_ready;
    assign o_out.valid       = r_out_valid;
    assign o_out.pos_left    = r_pos_left;
    assign o_out.pos_right   = r_pos_right;
    assign o_out.forward_vel = r_forward_vel;
    assign o_out.turn_rate   = r_turn_rate;

    a_tick_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && is_tick && r_out_valid && !o_out.ready |-> !in_ready)
        else $error("tick advanced over a held result");

    a_tick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && is_tick |=> r_out_valid)
        else $error("tick gave no result");

    a_set_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid && adv && !is_tick |=> !r_out_valid)
        else $error("non-tick item gave a result");

    a_enc_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && is_tick |=> r_pos_left == $signed($past(angle_left)))
        else $error("encoder not taken from pre-step angle");

endmodule

// ----- tb/sv/dc_motor_pair_euler_step_core_tb.sv -----
// ----------------------------------------------------------------------------
// dc_motor_pair_euler_step_core_tb
// Self-checking bench for the two-motor forward Euler step core. Items go in
// with random gaps, results come out under random and long stalls, and each
// tick result is matched against a bit-exact fixed-point motor pair predictor
// across default, zero, full-scale and random coefficient settings.
// ----------------------------------------------------------------------------
module dc_motor_pair_euler_step_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TICK_HZ = 60;
    localparam int Q_FRAC  = 16;
    localparam int MOTOR_L = 0;
    localparam int MOTOR_R = 1;

    localparam logic [dmpe_pkg::FUNC_W-1:0] FUNC_SPARE = 2'd3;

    localparam dmpe_pkg::t_q Q_TOP    = 32'sh7fff_ffff;
    localparam dmpe_pkg::t_q Q_BOTTOM = 32'sh8000_0000;
    localparam logic signed [63:0] Q_HI = 64'sd2147483647;
    localparam logic signed [63:0] Q_LO = -64'sd2147483648;

    typedef struct packed {
        dmpe_pkg::t_q pos_left;
        dmpe_pkg::t_q pos_right;
        dmpe_pkg::t_q forward_vel;
        dmpe_pkg::t_q turn_rate;
    } t_odom;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [dmpe_pkg::REG_IDX_W-1:0] i_cfg_idx;
    logic [dmpe_pkg::COEF_W-1:0]    i_cfg_data;

    dmpe_in_if  in_ch ();
    dmpe_out_if out_ch ();

    dc_motor_pair_euler_step_core #(
        .TICK_RATE(TICK_HZ),
        .FRAC_BITS(Q_FRAC)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch),
        .o_out     (out_ch),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    // predictor state
    dmpe_pkg::t_coef rst_plan [8] = '{
        dmpe_pkg::RST_SPEED_DECAY, dmpe_pkg::RST_TORQUE, dmpe_pkg::RST_BACK_EMF,
        dmpe_pkg::RST_RESIST, dmpe_pkg::RST_DRIVE, dmpe_pkg::RST_V_MAX,
        dmpe_pkg::RST_FWD_SCALE, dmpe_pkg::RST_TURN_SCALE};
    dmpe_pkg::t_coef coef_q [8];
    dmpe_pkg::t_coef coef_plan [8];
    dmpe_pkg::t_q    amp [2] = '{0, 0};
    dmpe_pkg::t_q    spd [2] = '{0, 0};
    dmpe_pkg::t_q    ang [2] = '{0, 0};
    dmpe_pkg::t_q    drv [2] = '{0, 0};
    t_odom odom_pending [$];
    t_odom odom_want;

    int fault_count = 0;
    bit src_idle    = 1'b1;
    bit sink_idle   = 1'b1;
    int sink_hold   = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(5_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

    // coefficient times value, rounded to nearest with ties away from zero
    function automatic logic signed [63:0] scale_round(input dmpe_pkg::t_coef c,
                                                       input logic signed [63:0] x);
        logic [63:0] mag;
        logic [63:0] acc;
        mag = (x < 0) ? 64'(-x) : 64'(x);
        acc = mag * 64'(c);
        acc = (acc + (64'd1 << (Q_FRAC - 1))) >> Q_FRAC;
        return (x < 0) ? -$signed(acc) : $signed(acc);
    endfunction

    function automatic dmpe_pkg::t_q clip32(input logic signed [63:0] v);
        if (v > Q_HI) return Q_TOP;
        if (v < Q_LO) return Q_BOTTOM;
        return v[31:0];
    endfunction

    // speed over tick rate, rounded to nearest with ties away from zero
    function automatic dmpe_pkg::t_q angle_step(input dmpe_pkg::t_q s);
        logic signed [63:0] x;
        logic [63:0] q;
        logic signed [63:0] r;
        x = s;
        q = (x < 0) ? 64'(-x) : 64'(x);
        q = (q + 64'(TICK_HZ / 2)) / 64'(TICK_HZ);
        r = (x < 0) ? -$signed(q) : $signed(q);
        return r[31:0];
    endfunction

    task automatic motor_pair_step(input logic [dmpe_pkg::FUNC_W-1:0] fn,
                                   input dmpe_pkg::t_q v);
        logic signed [63:0] lim;
        logic signed [63:0] x;
        logic signed [63:0] sp;
        logic signed [63:0] cu;
        logic signed [63:0] dsp;
        logic signed [63:0] dcu;
        logic signed [63:0] sl;
        logic signed [63:0] sr;
        t_odom res;
        lim = $signed({33'd0, coef_q[dmpe_pkg::REG_V_MAX]});
        x = v;
        if (x > lim) x = lim;
        if (x < -lim) x = -lim;
        case (fn)
            dmpe_pkg::FUNC_SET_LEFT: begin
                drv[MOTOR_L] = x[31:0];
            end
            dmpe_pkg::FUNC_SET_RIGHT: begin
                drv[MOTOR_R] = x[31:0];
            end
            dmpe_pkg::FUNC_TICK: begin
                sl = spd[MOTOR_L];
                sr = spd[MOTOR_R];
                res.pos_left    = ang[MOTOR_L];
                res.pos_right   = ang[MOTOR_R];
                res.forward_vel =
                    clip32(scale_round(coef_q[dmpe_pkg::REG_FWD_SCALE], sl + sr));
                res.turn_rate   =
                    clip32(scale_round(coef_q[dmpe_pkg::REG_TURN_SCALE], sr - sl));
                odom_pending.push_back(res);
                for (int m = 0; m < 2; m++) begin
                    sp = spd[m];
                    cu = amp[m];
                    dsp = scale_round(coef_q[dmpe_pkg::REG_TORQUE], cu)
                        - scale_round(coef_q[dmpe_pkg::REG_SPEED_DECAY], sp);
                    dcu = scale_round(coef_q[dmpe_pkg::REG_DRIVE], drv[m])
                        - scale_round(coef_q[dmpe_pkg::REG_BACK_EMF], sp)
                        - scale_round(coef_q[dmpe_pkg::REG_RESIST], cu);
                    ang[m] = ang[m] + angle_step(spd[m]);
                    spd[m] = clip32(sp + dsp);
                    amp[m] = clip32(cu + dcu);
                end
            end
            default: begin
            end
        endcase
    endtask

    // result check, register write tracking and prediction on accepted items
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                if (odom_pending.size() == 0) begin
                    fault_count++;
                    if (fault_count <= 10) begin
                        $display("unexpected result: pos_l %0d pos_r %0d fwd %0d turn %0d",
                                 out_ch.pos_left, out_ch.pos_right,
                                 out_ch.forward_vel, out_ch.turn_rate);
                    end
                end else begin
                    odom_want = odom_pending.pop_front();
                    if (out_ch.pos_left !== odom_want.pos_left
                            || out_ch.pos_right !== odom_want.pos_right
                            || out_ch.forward_vel !== odom_want.forward_vel
                            || out_ch.turn_rate !== odom_want.turn_rate) begin
                        fault_count++;
                        if (fault_count <= 10) begin
                            $display("mismatch at %0t: exp pos_l %0d pos_r %0d %0d %0d",
                                     $realtime, odom_want.pos_left, odom_want.pos_right,
                                     odom_want.forward_vel, odom_want.turn_rate);
                            $display("                 got pos_l %0d pos_r %0d %0d %0d",
                                     out_ch.pos_left, out_ch.pos_right,
                                     out_ch.forward_vel, out_ch.turn_rate);
                        end
                    end
                end
            end
            if (i_cfg_we) begin
                coef_q[i_cfg_idx] = i_cfg_data;
            end
            if (in_ch.valid && in_ch.ready) begin
                motor_pair_step(in_ch.func, in_ch.voltage);
            end
        end
    end

    // result side: per-item stall, plus a long hold-off on request
    initial begin : result_sink
        int n;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (sink_hold != 0) begin
                out_ch.ready <= 1'b0;
                repeat (sink_hold) @(posedge i_clk);
                sink_hold = 0;
            end
            n = sink_idle ? $urandom_range(0, 19) : 0;
            if (n != 0) begin
                out_ch.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    task automatic send_item(input logic [dmpe_pkg::FUNC_W-1:0] fn,
                             input dmpe_pkg::t_q v);
        int gap;
        gap = src_idle ? $urandom_range(0, 19) : 0;
        if (gap != 0) begin
            if (in_ch.valid) in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.func    <= fn;
        in_ch.voltage <= v;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // stop offering, wait for every pending result, let the pipeline empty
    task automatic wait_idle();
        int guard;
        guard = 0;
        if (in_ch.valid) in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (odom_pending.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apply_coefs();
        for (int k = 0; k < 8; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= dmpe_pkg::t_reg_idx'(k);
            i_cfg_data <= coef_plan[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_directed();
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        send_item(dmpe_pkg::FUNC_TICK, 32'sd0);
        send_item(dmpe_pkg::FUNC_SET_LEFT, Q_TOP);
        send_item(dmpe_pkg::FUNC_SET_RIGHT, Q_BOTTOM);
        send_item(dmpe_pkg::FUNC_TICK, 32'sd0);
        send_item(dmpe_pkg::FUNC_TICK, Q_TOP);
        send_item(dmpe_pkg::FUNC_TICK, Q_BOTTOM);
        send_item(FUNC_SPARE, 32'sh5a5a_a5a5);
        send_item(dmpe_pkg::FUNC_TICK, 32'sd0);
        send_item(dmpe_pkg::FUNC_SET_LEFT, 32'sd0);
        send_item(dmpe_pkg::FUNC_SET_RIGHT, -32'sd1);
        send_item(dmpe_pkg::FUNC_TICK, 32'sd0);
        send_item(dmpe_pkg::FUNC_SET_LEFT, 32'sd1);
        send_item(dmpe_pkg::FUNC_SET_RIGHT, 32'sh0005_0000);
        send_item(dmpe_pkg::FUNC_SET_LEFT, -32'sh0005_0000);
        send_item(dmpe_pkg::FUNC_TICK, 32'sd0);
        send_item(dmpe_pkg::FUNC_TICK, 32'sd0);
        send_item(FUNC_SPARE, Q_TOP);
        send_item(FUNC_SPARE, Q_BOTTOM);
        send_item(dmpe_pkg::FUNC_TICK, 32'sd0);
    endtask

    task automatic test_coef_extremes();
        // all coefficients zero: voltage clamps to zero, nothing moves
        wait_idle();
        foreach (coef_plan[k]) coef_plan[k] = '0;
        apply_coefs();
        send_item(dmpe_pkg::FUNC_SET_LEFT, Q_TOP);
        send_item(dmpe_pkg::FUNC_SET_RIGHT, Q_BOTTOM);
        repeat (3) send_item(dmpe_pkg::FUNC_TICK, 32'sd0);
        send_item(FUNC_SPARE, Q_TOP);
        send_item(dmpe_pkg::FUNC_TICK, 32'sd0);

        // no decay, back EMF or resistance: current and speed saturate, angles wrap
        wait_idle();
        foreach (coef_plan[k]) coef_plan[k] = '0;
        coef_plan[dmpe_pkg::REG_TORQUE]     = '1;
        coef_plan[dmpe_pkg::REG_DRIVE]      = '1;
        coef_plan[dmpe_pkg::REG_V_MAX]      = '1;
        coef_plan[dmpe_pkg::REG_FWD_SCALE]  = '1;
        coef_plan[dmpe_pkg::REG_TURN_SCALE] = '1;
        apply_coefs();
        send_item(dmpe_pkg::FUNC_SET_LEFT, Q_TOP);
        send_item(dmpe_pkg::FUNC_SET_RIGHT, Q_BOTTOM);
        repeat (70) send_item(dmpe_pkg::FUNC_TICK, 32'sd0);

        // every coefficient at full scale
        wait_idle();
        foreach (coef_plan[k]) coef_plan[k] = '1;
        apply_coefs();
        send_item(dmpe_pkg::FUNC_SET_LEFT, Q_BOTTOM);
        send_item(dmpe_pkg::FUNC_SET_RIGHT, Q_TOP);
        repeat (6) send_item(dmpe_pkg::FUNC_TICK, 32'sd0);
        send_item(dmpe_pkg::FUNC_SET_LEFT, 32'sd0);
        repeat (6) send_item(dmpe_pkg::FUNC_TICK, 32'sd0);
    endtask

    task automatic test_backpressure();
        wait_idle();
        coef_plan = rst_plan;
        apply_coefs();
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        sink_hold = 300;
        send_item(dmpe_pkg::FUNC_SET_LEFT, 32'sh0003_0000);
        send_item(dmpe_pkg::FUNC_SET_RIGHT, -32'sh0002_0000);
        for (int n = 0; n < 40; n++) begin
            if (n % 4 == 3) send_item(dmpe_pkg::FUNC_SET_LEFT, dmpe_pkg::t_q'($urandom));
            else send_item(dmpe_pkg::FUNC_TICK, dmpe_pkg::t_q'($urandom));
        end
        sink_idle = 1'b1;
        src_idle  = 1'b1;
    endtask

    task automatic test_random();
        int unsigned pick;
        dmpe_pkg::t_q v;
        for (int ph = 0; ph < 6; ph++) begin
            wait_idle();
            for (int k = 0; k < 8; k++) begin
                case (ph % 4)
                    0: coef_plan[k] = rst_plan[k];
                    1: coef_plan[k] =
                        dmpe_pkg::t_coef'($urandom_range(0, 2 * rst_plan[k]));
                    2: coef_plan[k] = dmpe_pkg::t_coef'($urandom);
                    default: coef_plan[k] =
                        dmpe_pkg::t_coef'($urandom_range(0, 32'h0001_0000));
                endcase
            end
            apply_coefs();
            for (int n = 0; n < 300; n++) begin
                if (n % 64 == 0) begin
                    src_idle  = $urandom_range(0, 1);
                    sink_idle = $urandom_range(0, 1);
                end
                case ($urandom_range(0, 4))
                    0, 1: v = dmpe_pkg::t_q'($urandom);
                    2, 3: v = dmpe_pkg::t_q'($urandom_range(0, 32'h000f_ffff))
                              - 32'sh0008_0000;
                    default: begin
                        v = dmpe_pkg::t_q'(coef_q[dmpe_pkg::REG_V_MAX]);
                        if ($urandom_range(0, 1)) v = -v;
                        if ($urandom_range(0, 1)) begin
                            v = v + dmpe_pkg::t_q'($urandom_range(0, 2)) - 1;
                        end
                    end
                endcase
                pick = $urandom_range(0, 99);
                if (pick < 28) send_item(dmpe_pkg::FUNC_SET_LEFT, v);
                else if (pick < 56) send_item(dmpe_pkg::FUNC_SET_RIGHT, v);
                else if (pick < 95) send_item(dmpe_pkg::FUNC_TICK, v);
                else send_item(FUNC_SPARE, v);
            end
        end
    endtask

    initial begin : regression
        i_rst_n       <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.func    <= dmpe_pkg::FUNC_SET_LEFT;
        in_ch.voltage <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= dmpe_pkg::REG_SPEED_DECAY;
        i_cfg_data    <= '0;
        coef_q = rst_plan;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_coef_extremes();
        test_backpressure();
        test_random();

        wait_idle();
        fault_count += odom_pending.size();
        if (fault_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/dmpe_pkg.sv
rtl/dmpe_in_if.sv
rtl/dmpe_out_if.sv
rtl/dmpe_cfg.sv
rtl/dmpe_mul_round.sv
rtl/dmpe_motor.sv
rtl/dc_motor_pair_euler_step_core.sv
tb/sv/dc_motor_pair_euler_step_core_tb.sv
